/* design/dtc_pkg.sv */
// Shared types, constants and helper functions of the double transposition cipher.
`timescale 1ns / 1ps
`default_nettype none
package dtc_pkg;

  localparam int CNT_W       = 7;
  localparam int KEY_SLOTS   = 8;
  localparam int KEY_IW      = 3;
  localparam int LEN_W       = 4;
  localparam int PERM_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam logic [7:0] PAD_CHAR = 8'h20;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd62;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_PERM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PERM = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
    logic       empty_result;
    logic       overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic pass_init;
    logic pass_step;
    logic pass_sel;
    logic bounds_plain;
    logic scan_init;
    logic scan_step;
    logic out_init;
    logic out_rd;
    logic out_ld;
    logic out_next;
    logic run_clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_valid;
    logic mode;
    logic div_done;
    logic pass_last;
    logic scan_done;
    logic out_fire;
    logic out_last;
  } sts_t;

  function automatic logic [KEY_IW-1:0] key_entry(input logic [PERM_W-1:0] perm,
                                                  input logic [KEY_IW-1:0] idx);
    key_entry = perm[KEY_IW*idx +: KEY_IW];
  endfunction

  // Entries below len must be in range and distinct
  function automatic logic perm_ok(input logic [LEN_W-1:0] len,
                                   input logic [PERM_W-1:0] perm);
    logic ok;
    ok = (len != '0) && (len <= LEN_W'(KEY_SLOTS));
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (LEN_W'(i) < len) begin
        if ({1'b0, perm[KEY_IW*i +: KEY_IW]} >= len) ok = 1'b0;
        for (int j = i + 1; j < KEY_SLOTS; j++) begin
          if (LEN_W'(j) < len && perm[KEY_IW*i +: KEY_IW] == perm[KEY_IW*j +: KEY_IW])
            ok = 1'b0;
        end
      end
    end
    perm_ok = ok;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
  endfunction

endpackage
`default_nettype wire

/* design/dtc_ctrl.sv */
// Controller state machine: sequences load, both passes, trim scan and readout.
`timescale 1ns / 1ps
`default_nettype none
module dtc_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_last,
  output logic              in_stall,
  input  wire dtc_pkg::sts_t sts,
  output dtc_pkg::cmd_t     cmd
);
  import dtc_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_CHECK, S_DIV, S_PASS, S_NEXT, S_DRAIN, S_SCAN, S_SCAN_END,
    S_OUT_INIT, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   pass_sel_r, pass_sel_nxt;

  assign in_stall = (state_r != S_LOAD);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    pass_sel_nxt = pass_sel_r;
    cmd          = '0;
    cmd.pass_sel = pass_sel_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        pass_sel_nxt = 1'b0;
        cmd.pass_sel = 1'b0;
        if (sts.key_valid) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.bounds_plain = 1'b1;
          state_nxt        = S_OUT_INIT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.pass_init = 1'b1;
          state_nxt     = S_PASS;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_PASS: begin
        cmd.pass_step = 1'b1;
        if (sts.pass_last) begin
          if (!pass_sel_r) begin
            pass_sel_nxt = 1'b1;
            state_nxt    = S_NEXT;
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_NEXT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DRAIN: begin
        if (sts.mode) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.bounds_plain = 1'b1;
          state_nxt        = S_OUT_INIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_OUT_INIT;
      S_OUT_INIT: begin
        cmd.out_init = 1'b1;
        state_nxt    = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts.out_fire) begin
          if (sts.out_last) begin
            cmd.run_clear = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      pass_sel_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pass_sel_r <= pass_sel_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/dtc_dp.sv */
// Datapath: config registers, text and middle stores, pass address generation, trim, output.
`timescale 1ns / 1ps
`default_nettype none
module dtc_dp #(
  parameter int MAX_KEY     = 8,
  parameter int MAX_TEXT    = 48,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dtc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire dtc_pkg::in_item_t                    in_data,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output dtc_pkg::out_item_t                        out_data,
  input  wire dtc_pkg::cmd_t                        cmd,
  output dtc_pkg::sts_t                             sts
);
  import dtc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int TEXT_CAP_I = (MAX_TEXT < STORE_DEPTH) ? MAX_TEXT : STORE_DEPTH;
  localparam logic [CNT_W-1:0] TEXT_CAP = CNT_W'(TEXT_CAP_I);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_DEPTH);
  localparam logic [LEN_W:0]   MAXK_C   = (LEN_W+1)'(MAX_KEY);

  // Configuration registers
  logic              mode_r;
  logic [LEN_W-1:0]  col_len_r, row_len_r;
  logic [PERM_W-1:0] col_perm_r, row_perm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      col_len_r  <= '0;
      col_perm_r <= '0;
      row_len_r  <= '0;
      row_perm_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_data[0];
        CFG_COL_LEN:  col_len_r  <= cfg_data[LEN_W-1:0];
        CFG_COL_PERM: col_perm_r <= cfg_data[PERM_W-1:0];
        CFG_ROW_LEN:  row_len_r  <= cfg_data[LEN_W-1:0];
        CFG_ROW_PERM: row_perm_r <= cfg_data[PERM_W-1:0];
        default: ;
      endcase
    end
  end

  logic key_valid;
  assign key_valid = perm_ok(col_len_r, col_perm_r) && perm_ok(row_len_r, row_perm_r)
                     && ({1'b0, col_len_r} <= MAXK_C) && ({1'b0, row_len_r} <= MAXK_C);

  // Pass selection: encrypt runs column then row, decrypt inverse row then inverse column
  logic              by_col, inv;
  logic [LEN_W-1:0]  n_sel;
  logic [PERM_W-1:0] perm_sel;
  assign by_col   = ~(cmd.pass_sel ^ mode_r);
  assign inv      = mode_r;
  assign n_sel    = by_col ? col_len_r : row_len_r;
  assign perm_sel = by_col ? col_perm_r : row_perm_r;

  // Length and overflow of the current run
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             load_we;
  assign load_we = cmd.load && (len_r < TEXT_CAP) && (len_r < DEPTH_C);

  // Grid depth by repeated addition
  logic [CNT_W-1:0] other_r, acc_r;
  logic             div_done;
  assign div_done = (acc_r >= len_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      other_r <= '0;
      acc_r   <= '0;
    end else if (cmd.div_step && !div_done) begin
      other_r <= other_r + CNT_W'(1);
      acc_r   <= acc_r + CNT_W'(n_sel);
    end
  end

  // Pass address generation
  logic [LEN_W-1:0]  a_r;
  logic [CNT_W-1:0]  b_r, pos_r, grid_r;
  logic [LEN_W-1:0]  a_inc;
  logic              b_last, pass_last;
  logic [CNT_W-1:0]  base0, base_next;
  logic [KEY_IW-1:0] k0, kn;
  logic [CNT_W+KEY_IW-1:0] prod0, prodn;
  logic [CNT_W-1:0]  rd_addr_p, wr_addr_p;
  logic              rd_pad_p;

  assign a_inc     = a_r + LEN_W'(1);
  assign b_last    = (b_r == other_r - CNT_W'(1));
  assign pass_last = b_last && (a_r == n_sel - LEN_W'(1));
  assign k0        = key_entry(perm_sel, '0);
  assign kn        = key_entry(perm_sel, a_inc[KEY_IW-1:0]);
  assign prod0     = k0 * other_r;
  assign prodn     = kn * other_r;
  assign base0     = by_col ? CNT_W'(k0) : prod0[CNT_W-1:0];
  assign base_next = by_col ? CNT_W'(kn) : prodn[CNT_W-1:0];
  assign rd_addr_p = inv ? pos_r : grid_r;
  assign wr_addr_p = inv ? grid_r : pos_r;
  assign rd_pad_p  = (rd_addr_p >= len_r) || (rd_addr_p >= DEPTH_C);

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      a_r    <= '0;
      b_r    <= '0;
      pos_r  <= '0;
      grid_r <= base0;
    end else if (cmd.pass_step) begin
      pos_r <= pos_r + CNT_W'(1);
      if (b_last) begin
        a_r    <= a_inc;
        b_r    <= '0;
        grid_r <= base_next;
      end else begin
        b_r    <= b_r + CNT_W'(1);
        grid_r <= grid_r + (by_col ? CNT_W'(n_sel) : CNT_W'(1));
      end
    end
  end

  // Write-back stage of a pass
  logic             pw_en_r;
  logic [CNT_W-1:0] pw_addr_r;
  logic             pw_pad_r, pw_to_text_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pw_en_r <= 1'b0;
    else        pw_en_r <= cmd.pass_step;
  end
  always_ff @(posedge clk) begin
    pw_addr_r    <= wr_addr_p;
    pw_pad_r     <= rd_pad_p;
    pw_to_text_r <= cmd.pass_sel;
  end

  // Trim scan
  logic [CNT_W-1:0] sc_idx_r, sc_ia_r, start_r, stop_r, lim;
  logic             sc_v_r, found_r, scan_issue;
  assign lim        = (len_r < DEPTH_C) ? len_r : DEPTH_C;
  assign scan_issue = cmd.scan_step && (sc_idx_r < lim);

  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else        sc_v_r <= scan_issue;
  end

  // Stores and their read ports
  logic [7:0] text_mem [STORE_DEPTH];
  logic [7:0] mid_mem  [STORE_DEPTH];
  logic [7:0] txt_rdata_r, mid_rdata_r, pw_data;
  logic [CNT_W-1:0] out_n_r, out_idx_r, out_addr, txt_raddr;
  logic             pw_ok;

  assign out_addr  = start_r + out_idx_r;
  assign txt_raddr = cmd.scan_step ? sc_idx_r : (cmd.out_rd ? out_addr : rd_addr_p);
  assign pw_data   = pw_pad_r ? PAD_CHAR : (pw_to_text_r ? mid_rdata_r : txt_rdata_r);
  assign pw_ok     = pw_en_r && (pw_addr_r < DEPTH_C);

  always_ff @(posedge clk) begin
    if (load_we) begin
      text_mem[len_r[AW-1:0]] <= in_data.char_in;
    end else if (pw_ok && pw_to_text_r) begin
      text_mem[pw_addr_r[AW-1:0]] <= pw_data;
    end
    txt_rdata_r <= text_mem[txt_raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pw_ok && !pw_to_text_r) begin
      mid_mem[pw_addr_r[AW-1:0]] <= pw_data;
    end
    mid_rdata_r <= mid_mem[rd_addr_p[AW-1:0]];
  end

  // Scan bounds
  always_ff @(posedge clk) begin
    if (cmd.bounds_plain) begin
      start_r <= '0;
      stop_r  <= lim;
    end else if (cmd.scan_init) begin
      sc_idx_r <= '0;
      found_r  <= 1'b0;
      start_r  <= '0;
      stop_r   <= '0;
    end else begin
      if (scan_issue) begin
        sc_idx_r <= sc_idx_r + CNT_W'(1);
        sc_ia_r  <= sc_idx_r;
      end
      if (sc_v_r && !is_blank(txt_rdata_r)) begin
        if (!found_r) start_r <= sc_ia_r;
        found_r <= 1'b1;
        stop_r  <= sc_ia_r + CNT_W'(1);
      end
    end
  end

  // Run length and overflow
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (cmd.run_clear) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.load) begin
      if (load_we) len_nxt = len_r + CNT_W'(1);
      else         ovf_nxt = 1'b1;
    end else if (cmd.pass_step && pass_last) begin
      len_nxt = pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Output item register
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [CNT_W-1:0] span;
  logic             out_empty;
  assign span      = stop_r - start_r;
  assign out_empty = (out_n_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.out_init) begin
      out_n_r   <= (span > MAX_RESULTS) ? MAX_RESULTS : span;
      out_idx_r <= '0;
    end else if (cmd.out_next) begin
      out_idx_r <= out_idx_r + CNT_W'(1);
    end
    if (cmd.out_ld) begin
      out_data_r.char_out     <= out_empty ? 8'h00 : txt_rdata_r;
      out_data_r.last_out     <= out_empty || (out_idx_r + CNT_W'(1) == out_n_r);
      out_data_r.empty_result <= out_empty;
      out_data_r.overflow     <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)               out_valid_r <= 1'b0;
    else if (cmd.out_ld)      out_valid_r <= 1'b1;
    else if (!out_stall)      out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.key_valid = key_valid;
    sts.mode      = mode_r;
    sts.div_done  = div_done;
    sts.pass_last = pass_last;
    sts.scan_done = (sc_idx_r >= lim);
    sts.out_fire  = out_valid_r && !out_stall;
    sts.out_last  = out_data_r.last_out;
  end

endmodule
`default_nettype wire

/* design/double_transposition_cipher.sv */
// Top level of the double transposition cipher: controller plus datapath.
//
// Usage: write mode, column key and row key over the cfg_ channel (index,
// data; cfg_ready is always high) while the block is idle. Then send the
// message one character per item on the in_ channel, marking the final
// character with last_in. Characters past the text capacity are dropped and
// flag overflow on every result item of that message.
// After the final character the block stalls its input, runs two passes over
// its character stores when both keys are valid (one store access per cycle,
// each grid first sized by repeated addition), scans for whitespace trim when
// decrypting, and then emits the result on the out_ channel, loading each
// item only after the previous one is taken, the final one marked by
// last_out. An all-blank decrypt result gives a single item with
// empty_result set.
// The output item sits in a register and holds while out_stall is high.
// Reset (rst_n low at a clock edge) clears the config registers, the
// character count and all handshake state; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module double_transposition_cipher #(
  parameter int MAX_KEY     = 8,
  parameter int MAX_TEXT    = 48,
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire dtc_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output dtc_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dtc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_in),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtc_dp #(
    .MAX_KEY     (MAX_KEY),
    .MAX_TEXT    (MAX_TEXT),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
